>>> sv/aesc_pkg.sv
// Shared constants, codes and types of the auto-exposure step controller.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none
package aesc_pkg;

  localparam int PIX_W   = 32;
  localparam int SUM_W   = 40;
  localparam int TGT_W   = 8;
  localparam int LIM_W   = 16;
  localparam int EXPO_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int DGAIN_W = 8;
  localparam int FAC_W   = 6;
  localparam int PROD_W  = PIX_W + TGT_W;     // pixel count times luma goal
  localparam int NUM_W   = PROD_W + 5;        // scaled by 16, plus half the sum
  localparam int MUL_W   = LIM_W + FAC_W;     // control * factor
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one restoring step for each quotient bit, the top one only detects saturation
  localparam int DIV_STEPS = FAC_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam logic [FAC_W-1:0]   FACTOR_MAX     = 6'd32;
  localparam logic [FAC_W-1:0]   UP_THRESHOLD   = 6'd18;
  localparam logic [FAC_W-1:0]   DOWN_THRESHOLD = 6'd14;
  localparam logic [DGAIN_W-1:0] DGAIN_CAP      = 8'hff;
  localparam logic [GAIN_W-1:0]  GAIN_FLOOR     = 16'd16;
  localparam logic [EXPO_W-1:0]  EXPO_FLOOR     = 16'd1;

  localparam logic [TGT_W-1:0] TARGET_RESET     = 8'd128;
  localparam logic [LIM_W-1:0] EXPO_LIMIT_RESET = 16'hffff;
  localparam logic [LIM_W-1:0] GAIN_LIMIT_RESET = 16'hffff;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LUMA    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPOSURE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LIMIT     = 2'd2;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [SUM_W-1:0] sum;
  } q_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SCALE,
    BK_APPLY
  } back_state_t;

  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_EXPO,
    SEL_GAIN,
    SEL_DGAIN
  } ctrl_sel_t;

endpackage
`default_nettype wire

>>> sv/aesc_if.sv
// Handshake channels of the auto-exposure step controller: frame statistics in,
// control update out. Depends on aesc_pkg for field widths.
`default_nettype none
interface aesc_stats_if;
  logic                            valid;
  logic                            ready;
  logic [aesc_pkg::PIX_W-1:0]      pixel_count;
  logic [aesc_pkg::SUM_W-1:0]      luma_total;

  modport source (output valid, output pixel_count, output luma_total, input ready);
  modport sink   (input valid, input pixel_count, input luma_total, output ready);
endinterface

interface aesc_result_if;
  logic                            valid;
  logic                            ready;
  logic [aesc_pkg::EXPO_W-1:0]     exposure;
  logic [aesc_pkg::GAIN_W-1:0]     sensor_gain;
  logic [aesc_pkg::DGAIN_W-1:0]    digital_gain;
  logic                            exposure_changed;
  logic                            gain_changed;
  logic                            dgain_changed;
  logic [aesc_pkg::FAC_W-1:0]      brightness_factor;

  modport source (output valid, output exposure, output sensor_gain, output digital_gain,
                  output exposure_changed, output gain_changed, output dgain_changed,
                  output brightness_factor, input ready);
  modport sink   (input valid, input exposure, input sensor_gain, input digital_gain,
                  input exposure_changed, input gain_changed, input dgain_changed,
                  input brightness_factor, output ready);
endinterface
`default_nettype wire

>>> sv/aesc_queue.sv
// Short queue between the front (statistics scaling) and the back (divide, update).
// Depends on aesc_pkg for the entry type and depth.
`default_nettype none
module aesc_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire aesc_pkg::q_entry_t push_data,
  output logic                   full,
  input  wire logic              pop,
  output aesc_pkg::q_entry_t     pop_data,
  output logic                   empty
);

  aesc_pkg::q_entry_t               mem [aesc_pkg::QUEUE_DEPTH];
  logic [aesc_pkg::QPTR_W-1:0]      wr_ptr;
  logic [aesc_pkg::QPTR_W-1:0]      rd_ptr;
  logic [aesc_pkg::QCNT_W-1:0]      count;

  assign full     = (count == aesc_pkg::QCNT_W'(aesc_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/aesc_front.sv
// Front of the controller: accept frame statistics, form the division numerator
// pixel_count*target*16 + luma_total/2 and push it with the sum. Uses aesc_pkg, aesc_if.
`default_nettype none
module aesc_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [aesc_pkg::TGT_W-1:0]  luma_goal,
  aesc_stats_if.sink                       stats,
  output logic                             push,
  output aesc_pkg::q_entry_t               push_data,
  input  wire logic                        q_full
);

  logic                          stage_valid;
  logic [aesc_pkg::PIX_W-1:0]    stage_pix;
  logic [aesc_pkg::SUM_W-1:0]    stage_sum;
  logic [aesc_pkg::PROD_W-1:0]   prod;

  assign stats.ready = !stage_valid || !q_full;
  assign push        = stage_valid && !q_full;

  assign prod = aesc_pkg::PROD_W'(stage_pix) * aesc_pkg::PROD_W'(luma_goal);
  assign push_data.num = {1'b0, prod, 4'b0000} + aesc_pkg::NUM_W'(stage_sum >> 1);
  assign push_data.sum = stage_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stats.valid && stats.ready) begin
      stage_valid <= 1'b1;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stats.valid && stats.ready) begin
      stage_pix <= stats.pixel_count;
      stage_sum <= stats.luma_total;
    end
  end

endmodule
`default_nettype wire

>>> sv/aesc_back.sv
// Back of the controller: restoring divide for the brightness factor, one control
// step in priority order, and the result register. Uses aesc_pkg, aesc_if.
`default_nettype none
module aesc_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [aesc_pkg::LIM_W-1:0]  exposure_limit,
  input  wire logic [aesc_pkg::LIM_W-1:0]  gain_limit,
  output logic                             pop,
  input  wire aesc_pkg::q_entry_t          pop_data,
  input  wire logic                        q_empty,
  aesc_result_if.source                    result
);

  aesc_pkg::back_state_t             state;
  aesc_pkg::back_state_t             state_next;
  logic                              load;

  logic [aesc_pkg::NUM_W-1:0]        rem;
  logic [aesc_pkg::NUM_W-1:0]        den;
  logic [aesc_pkg::DCNT_W-1:0]       cnt;
  logic [aesc_pkg::FAC_W-1:0]        quot;
  logic                              ge;

  logic [aesc_pkg::EXPO_W-1:0]       cur_expo;
  logic [aesc_pkg::GAIN_W-1:0]       cur_sgain;
  logic [aesc_pkg::DGAIN_W-1:0]      cur_dgain;

  aesc_pkg::ctrl_sel_t               sel_comb;
  logic [aesc_pkg::LIM_W-1:0]        cur_comb;
  logic [aesc_pkg::LIM_W-1:0]        bound_comb;
  logic                              up_comb;

  aesc_pkg::ctrl_sel_t               sel;
  logic                              up;
  logic [aesc_pkg::LIM_W-1:0]        cur;
  logic [aesc_pkg::LIM_W-1:0]        bound;
  logic [aesc_pkg::MUL_W-1:0]        prod;

  logic [aesc_pkg::MUL_W-5:0]        scaled;
  logic [aesc_pkg::MUL_W-5:0]        diff;
  logic [aesc_pkg::MUL_W-5:0]        step;
  logic [aesc_pkg::MUL_W-5:0]        raised;
  logic [aesc_pkg::LIM_W-1:0]        new_val;
  logic [aesc_pkg::EXPO_W-1:0]       ne;
  logic [aesc_pkg::GAIN_W-1:0]       ng;
  logic [aesc_pkg::DGAIN_W-1:0]      nd;

  assign ge = (rem >= den);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aesc_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load       = 1'b0;
    case (state)
      aesc_pkg::BK_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          state_next = (pop_data.sum == '0) ? aesc_pkg::BK_SCALE : aesc_pkg::BK_DIV;
        end
      end
      aesc_pkg::BK_DIV: begin
        // the top step only tells whether the quotient saturates
        if ((cnt == aesc_pkg::DCNT_W'(aesc_pkg::DIV_STEPS - 1) && ge) || cnt == '0) begin
          state_next = aesc_pkg::BK_SCALE;
        end
      end
      aesc_pkg::BK_SCALE: begin
        state_next = aesc_pkg::BK_APPLY;
      end
      aesc_pkg::BK_APPLY: begin
        if (!result.valid || result.ready) begin
          load       = 1'b1;
          state_next = aesc_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = aesc_pkg::BK_IDLE;
      end
    endcase
  end

  // divider
  always_ff @(posedge clk) begin
    if (state == aesc_pkg::BK_IDLE && pop) begin
      rem  <= pop_data.num;
      den  <= {pop_data.sum, 5'b00000};
      cnt  <= aesc_pkg::DCNT_W'(aesc_pkg::DIV_STEPS - 1);
      quot <= (pop_data.sum == '0) ? aesc_pkg::FACTOR_MAX : '0;
    end else if (state == aesc_pkg::BK_DIV) begin
      if (cnt == aesc_pkg::DCNT_W'(aesc_pkg::DIV_STEPS - 1) && ge) begin
        quot <= aesc_pkg::FACTOR_MAX;
      end else begin
        quot <= {quot[aesc_pkg::FAC_W-2:0], ge};
        if (ge) begin
          rem <= rem - den;
        end
      end
      den <= den >> 1;
      cnt <= cnt - 1'b1;
    end
  end

  // pick the one control to move, in priority order
  always_comb begin
    up_comb    = (quot > aesc_pkg::UP_THRESHOLD);
    sel_comb   = aesc_pkg::SEL_NONE;
    cur_comb   = '0;
    bound_comb = '0;
    if (up_comb) begin
      if (cur_expo < exposure_limit) begin
        sel_comb = aesc_pkg::SEL_EXPO;
      end else if (cur_sgain < gain_limit) begin
        sel_comb = aesc_pkg::SEL_GAIN;
      end else if (cur_dgain < aesc_pkg::DGAIN_CAP) begin
        sel_comb = aesc_pkg::SEL_DGAIN;
      end
    end else if (quot < aesc_pkg::DOWN_THRESHOLD) begin
      if (cur_dgain > aesc_pkg::DGAIN_W'(aesc_pkg::GAIN_FLOOR)) begin
        sel_comb = aesc_pkg::SEL_DGAIN;
      end else if (cur_sgain > aesc_pkg::GAIN_FLOOR) begin
        sel_comb = aesc_pkg::SEL_GAIN;
      end else if (cur_expo > aesc_pkg::EXPO_FLOOR) begin
        sel_comb = aesc_pkg::SEL_EXPO;
      end
    end
    case (sel_comb)
      aesc_pkg::SEL_EXPO: begin
        cur_comb   = cur_expo;
        bound_comb = up_comb ? exposure_limit : aesc_pkg::EXPO_FLOOR;
      end
      aesc_pkg::SEL_GAIN: begin
        cur_comb   = cur_sgain;
        bound_comb = up_comb ? gain_limit : aesc_pkg::GAIN_FLOOR;
      end
      aesc_pkg::SEL_DGAIN: begin
        cur_comb   = aesc_pkg::LIM_W'(cur_dgain);
        bound_comb = up_comb ? aesc_pkg::LIM_W'(aesc_pkg::DGAIN_CAP) : aesc_pkg::GAIN_FLOOR;
      end
      default: begin
        cur_comb   = '0;
        bound_comb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == aesc_pkg::BK_SCALE) begin
      sel   <= sel_comb;
      up    <= up_comb;
      cur   <= cur_comb;
      bound <= bound_comb;
      prod  <= aesc_pkg::MUL_W'(cur_comb) * aesc_pkg::MUL_W'(quot);
    end
  end

  // half the scaled difference, at least one, clamped to the bound
  always_comb begin
    scaled = prod[aesc_pkg::MUL_W-1:4];
    if (up) begin
      diff = scaled - (aesc_pkg::MUL_W-4)'(cur);
    end else begin
      diff = (aesc_pkg::MUL_W-4)'(cur) - scaled;
    end
    step = diff >> 1;
    if (step == '0) begin
      step = (aesc_pkg::MUL_W-4)'(1);
    end
    raised = (aesc_pkg::MUL_W-4)'(cur) + step;
    if (up) begin
      new_val = (raised > (aesc_pkg::MUL_W-4)'(bound)) ? bound : raised[aesc_pkg::LIM_W-1:0];
    end else begin
      new_val = ((aesc_pkg::MUL_W-4)'(cur) < (aesc_pkg::MUL_W-4)'(bound) + step) ?
                bound : cur - step[aesc_pkg::LIM_W-1:0];
    end
    ne = cur_expo;
    ng = cur_sgain;
    nd = cur_dgain;
    case (sel)
      aesc_pkg::SEL_EXPO:  ne = new_val;
      aesc_pkg::SEL_GAIN:  ng = new_val;
      aesc_pkg::SEL_DGAIN: nd = new_val[aesc_pkg::DGAIN_W-1:0];
      default:             ne = cur_expo;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_expo     <= aesc_pkg::EXPO_FLOOR;
      cur_sgain    <= aesc_pkg::GAIN_FLOOR;
      cur_dgain    <= aesc_pkg::DGAIN_W'(aesc_pkg::GAIN_FLOOR);
      result.valid <= 1'b0;
    end else begin
      if (load) begin
        cur_expo     <= ne;
        cur_sgain    <= ng;
        cur_dgain    <= nd;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.exposure          <= ne;
      result.sensor_gain       <= ng;
      result.digital_gain      <= nd;
      result.exposure_changed  <= (ne != cur_expo);
      result.gain_changed      <= (ng != cur_sgain);
      result.dgain_changed     <= (nd != cur_dgain);
      result.brightness_factor <= quot;
    end
  end

`ifndef SYNTHESIS
  a_factor_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.brightness_factor <= aesc_pkg::FACTOR_MAX)
    else $error("brightness factor above saturation");

  a_one_control: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> $countones({result.exposure_changed, result.gain_changed,
                                 result.dgain_changed}) <= 1)
    else $error("more than one control moved in one frame");

  a_state_match: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.exposure == cur_expo && result.sensor_gain == cur_sgain &&
                      result.digital_gain == cur_dgain))
    else $error("pending result differs from the held control values");

  a_floors: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.exposure >= aesc_pkg::EXPO_FLOOR &&
                      result.sensor_gain >= aesc_pkg::GAIN_FLOOR &&
                      result.digital_gain >= aesc_pkg::DGAIN_W'(aesc_pkg::GAIN_FLOOR)))
    else $error("control below its floor");
`endif

endmodule
`default_nettype wire

>>> sv/auto_exposure_step_controller_unit.sv
// Top level of the auto-exposure step controller: configuration registers,
// front, queue and back. Uses aesc_pkg, aesc_if, aesc_front, aesc_queue, aesc_back.
`default_nettype none
// Takes one frame's statistics (pixel count, luma sum) per request and returns one
// control update: new exposure, sensor gain and digital gain, a change flag for each,
// and the Q4 brightness factor. The front registers a request and forms the numerator
// from the registered values, handing it through a two-entry queue; the back takes one
// request at a time: it pops it, runs six steps of the restoring divider for the
// factor, multiplies the chosen control by the factor and then clamps and registers
// the result. The divider stops after its first step when the factor saturates there
// and is skipped when the luma sum is zero, and a result not yet taken holds the
// back. The result stays in its output register until taken; the back does not
// load a new one before then.
// Write the luma goal, exposure_limit and gain_limit only while no request is in flight.
module auto_exposure_step_controller_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [aesc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [aesc_pkg::CFG_DAT_W-1:0]  cfg_data,
  aesc_stats_if.sink                           stats,
  aesc_result_if.source                        result
);

  logic [aesc_pkg::TGT_W-1:0]   luma_goal;
  logic [aesc_pkg::LIM_W-1:0]   exposure_limit;
  logic [aesc_pkg::LIM_W-1:0]   gain_limit;

  logic                         push;
  aesc_pkg::q_entry_t           push_data;
  logic                         q_full;
  logic                         pop;
  aesc_pkg::q_entry_t           pop_data;
  logic                         q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      luma_goal      <= aesc_pkg::TARGET_RESET;
      exposure_limit <= aesc_pkg::EXPO_LIMIT_RESET;
      gain_limit     <= aesc_pkg::GAIN_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        aesc_pkg::CFG_TARGET_LUMA:    luma_goal      <= cfg_data[aesc_pkg::TGT_W-1:0];
        aesc_pkg::CFG_EXPOSURE_LIMIT: exposure_limit <= cfg_data[aesc_pkg::LIM_W-1:0];
        aesc_pkg::CFG_GAIN_LIMIT:     gain_limit     <= cfg_data[aesc_pkg::LIM_W-1:0];
        default:                      luma_goal      <= luma_goal;
      endcase
    end
  end

  aesc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .luma_goal   (luma_goal),
    .stats       (stats),
    .push        (push),
    .push_data   (push_data),
    .q_full      (q_full)
  );

  aesc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  aesc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .exposure_limit (exposure_limit),
    .gain_limit     (gain_limit),
    .pop            (pop),
    .pop_data       (pop_data),
    .q_empty        (q_empty),
    .result         (result)
  );

endmodule
`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for auto_exposure_step_controller_unit: frame statistics in,
// exposure/gain updates out, checked against an in-bench exposure loop model.
// Depends on aesc_pkg and the aesc_stats_if / aesc_result_if interfaces.
`timescale 1ns / 100ps
module tb;

  localparam int STUCK_LIMIT = 4000;

  typedef struct {
    logic [aesc_pkg::PIX_W-1:0] pix;
    logic [aesc_pkg::SUM_W-1:0] sum;
    bit                         hold;   // send only once every update has come back
  } frame_t;

  typedef struct packed {
    logic [aesc_pkg::EXPO_W-1:0]  exposure;
    logic [aesc_pkg::GAIN_W-1:0]  sensor_gain;
    logic [aesc_pkg::DGAIN_W-1:0] digital_gain;
    logic                         exposure_changed;
    logic                         gain_changed;
    logic                         dgain_changed;
    logic [aesc_pkg::FAC_W-1:0]   brightness_factor;
  } ctrl_update_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [aesc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [aesc_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  aesc_stats_if  stats_ch ();
  aesc_result_if upd_ch ();

  auto_exposure_step_controller_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stats     (stats_ch),
    .result    (upd_ch)
  );

  always #2 clk = ~clk;

  // loop model: register copies and the current control triple
  int unsigned tgt_luma = 32'(aesc_pkg::TARGET_RESET);
  int unsigned expo_lim = 32'(aesc_pkg::EXPO_LIMIT_RESET);
  int unsigned gain_lim = 32'(aesc_pkg::GAIN_LIMIT_RESET);
  int unsigned cur_expo = 32'(aesc_pkg::EXPO_FLOOR);
  int unsigned cur_sgain = 32'(aesc_pkg::GAIN_FLOOR);
  int unsigned cur_dgain = 32'(aesc_pkg::GAIN_FLOOR);

  frame_t       pending_frames[$];
  ctrl_update_t expected_updates[$];

  int unsigned fail_count = 0;
  int unsigned frames_sent = 0;
  int unsigned updates_checked = 0;
  int unsigned expo_moves = 0, gain_moves = 0, dgain_moves = 0;
  int unsigned settings_used = 0;
  int unsigned stuck_cycles = 0;

  function automatic int unsigned up_step(int unsigned cur, int unsigned f);
    int unsigned d;
    d = (((cur * f) >> 4) - cur) >> 1;
    return (d != 0) ? d : 1;
  endfunction

  function automatic int unsigned down_step(int unsigned cur, int unsigned f);
    int unsigned d;
    d = (cur - ((cur * f) >> 4)) >> 1;
    return (d != 0) ? d : 1;
  endfunction

  function automatic int unsigned clamp_up(int unsigned cur, int unsigned d, int unsigned hi);
    return (cur + d > hi) ? hi : cur + d;
  endfunction

  function automatic int unsigned clamp_down(int unsigned cur, int unsigned d, int unsigned lo);
    return (cur < lo + d) ? lo : cur - d;
  endfunction

  function automatic ctrl_update_t predict_update(logic [aesc_pkg::PIX_W-1:0] pix,
                                                  logic [aesc_pkg::SUM_W-1:0] sum);
    bit [63:0]    q;
    int unsigned  f, ne, ng, nd;
    ctrl_update_t u;
    ne = cur_expo;
    ng = cur_sgain;
    nd = cur_dgain;
    if (sum == '0) begin
      f = 32'(aesc_pkg::FACTOR_MAX);
    end else begin
      q = (64'(pix) * 64'(tgt_luma) * 64'd16 + 64'(sum >> 1)) / 64'(sum);
      f = (q > 64'(aesc_pkg::FACTOR_MAX)) ? 32'(aesc_pkg::FACTOR_MAX) : 32'(q);
    end
    // too dark: raise exposure, then sensor gain, then digital gain
    if (f > 32'(aesc_pkg::UP_THRESHOLD)) begin
      if (ne < expo_lim)
        ne = clamp_up(ne, up_step(ne, f), expo_lim);
      else if (ng < gain_lim)
        ng = clamp_up(ng, up_step(ng, f), gain_lim);
      else if (nd < 32'(aesc_pkg::DGAIN_CAP))
        nd = clamp_up(nd, up_step(nd, f), 32'(aesc_pkg::DGAIN_CAP));
    end else if (f < 32'(aesc_pkg::DOWN_THRESHOLD)) begin
      if (nd > 32'(aesc_pkg::GAIN_FLOOR))
        nd = clamp_down(nd, down_step(nd, f), 32'(aesc_pkg::GAIN_FLOOR));
      else if (ng > 32'(aesc_pkg::GAIN_FLOOR))
        ng = clamp_down(ng, down_step(ng, f), 32'(aesc_pkg::GAIN_FLOOR));
      else if (ne > 32'(aesc_pkg::EXPO_FLOOR))
        ne = clamp_down(ne, down_step(ne, f), 32'(aesc_pkg::EXPO_FLOOR));
    end
    u.exposure          = aesc_pkg::EXPO_W'(ne);
    u.sensor_gain       = aesc_pkg::GAIN_W'(ng);
    u.digital_gain      = aesc_pkg::DGAIN_W'(nd);
    u.exposure_changed  = (32'(aesc_pkg::EXPO_W'(ne)) != cur_expo);
    u.gain_changed      = (32'(aesc_pkg::GAIN_W'(ng)) != cur_sgain);
    u.dgain_changed     = (32'(aesc_pkg::DGAIN_W'(nd)) != cur_dgain);
    u.brightness_factor = aesc_pkg::FAC_W'(f);
    cur_expo  = 32'(aesc_pkg::EXPO_W'(ne));
    cur_sgain = 32'(aesc_pkg::GAIN_W'(ng));
    cur_dgain = 32'(aesc_pkg::DGAIN_W'(nd));
    return u;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 60)
      return 0;
    else if (r < 92)
      return $urandom_range(3, 1);
    else
      return $urandom_range(40, 8);
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("tb: %s expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // request driver
  always @(posedge clk) begin : drive_stats
    frame_t      fr;
    int unsigned send_gap;
    int unsigned calm_items;
    if (rst) begin
      stats_ch.valid <= 1'b0;
      send_gap = 0;
      calm_items = 0;
    end else begin
      if (stats_ch.valid && stats_ch.ready) begin
        expected_updates.push_back(predict_update(stats_ch.pixel_count, stats_ch.luma_total));
        frames_sent++;
      end
      if (!stats_ch.valid || stats_ch.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          stats_ch.valid <= 1'b0;
        end else if (pending_frames.size() != 0 &&
                     !(pending_frames[0].hold && expected_updates.size() != 0)) begin
          fr = pending_frames.pop_front();
          stats_ch.valid       <= 1'b1;
          stats_ch.pixel_count <= fr.pix;
          stats_ch.luma_total  <= fr.sum;
          if (calm_items != 0) begin
            calm_items--;
          end else begin
            send_gap = pick_gap();
            if ($urandom_range(39, 0) == 0)
              calm_items = $urandom_range(60, 20);
          end
        end else begin
          stats_ch.valid <= 1'b0;
        end
      end
    end
  end

  // update monitor and checker
  always @(posedge clk) begin : check_updates
    ctrl_update_t want;
    int unsigned  stall;
    int unsigned  calm_cycles;
    if (rst) begin
      upd_ch.ready <= 1'b0;
      stall = 0;
      calm_cycles = 0;
    end else begin
      if (upd_ch.valid && upd_ch.ready) begin
        if (expected_updates.size() == 0) begin
          $error("tb: update with no request outstanding");
          fail_count++;
        end else begin
          want = expected_updates.pop_front();
          check_field("exposure", 16'(want.exposure), 16'(upd_ch.exposure));
          check_field("sensor_gain", 16'(want.sensor_gain), 16'(upd_ch.sensor_gain));
          check_field("digital_gain", 16'(want.digital_gain), 16'(upd_ch.digital_gain));
          check_field("exposure_changed", 16'(want.exposure_changed),
                      16'(upd_ch.exposure_changed));
          check_field("gain_changed", 16'(want.gain_changed), 16'(upd_ch.gain_changed));
          check_field("dgain_changed", 16'(want.dgain_changed), 16'(upd_ch.dgain_changed));
          check_field("brightness_factor", 16'(want.brightness_factor),
                      16'(upd_ch.brightness_factor));
          updates_checked++;
          expo_moves  += 32'(want.exposure_changed);
          gain_moves  += 32'(want.gain_changed);
          dgain_moves += 32'(want.dgain_changed);
        end
      end
      if (stall != 0) begin
        stall--;
        upd_ch.ready <= 1'b0;
      end else begin
        upd_ch.ready <= 1'b1;
        if (calm_cycles != 0) begin
          calm_cycles--;
        end else begin
          stall = pick_gap();
          if ($urandom_range(199, 0) == 0)
            calm_cycles = $urandom_range(300, 50);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (stats_ch.valid && stats_ch.ready) || (upd_ch.valid && upd_ch.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin : watchdog
    while (stuck_cycles < STUCK_LIMIT)
      @(posedge clk);
    $display("tb: nothing accepted for %0d cycles", STUCK_LIMIT);
    $display("tb: FAIL");
    $finish;
  end

  task automatic write_reg(input logic [aesc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [aesc_pkg::CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      aesc_pkg::CFG_TARGET_LUMA:    tgt_luma = 32'(val[aesc_pkg::TGT_W-1:0]);
      aesc_pkg::CFG_EXPOSURE_LIMIT: expo_lim = 32'(val[aesc_pkg::LIM_W-1:0]);
      aesc_pkg::CFG_GAIN_LIMIT:     gain_lim = 32'(val[aesc_pkg::LIM_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic program_loop(input logic [aesc_pkg::TGT_W-1:0] tgt,
                              input logic [aesc_pkg::LIM_W-1:0] elim,
                              input logic [aesc_pkg::LIM_W-1:0] glim);
    write_reg(aesc_pkg::CFG_TARGET_LUMA, aesc_pkg::CFG_DAT_W'(tgt));
    write_reg(aesc_pkg::CFG_EXPOSURE_LIMIT, elim);
    write_reg(aesc_pkg::CFG_GAIN_LIMIT, glim);
    settings_used++;
  endtask

  task automatic add_frame(input logic [aesc_pkg::PIX_W-1:0] pix,
                           input logic [aesc_pkg::SUM_W-1:0] sum,
                           input bit hold);
    pending_frames.push_back('{pix, sum, hold});
  endtask

  // hold off config writes until the pipeline has drained
  task automatic wait_idle();
    while (pending_frames.size() != 0 || stats_ch.valid || expected_updates.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // with target 128 and a sum of 2048 the factor equals the pixel count
  task automatic queue_directed();
    add_frame('0, '0, 1'b0);               // zero sum: full brightening
    add_frame(32'd32, 40'd2048, 1'b0);
    add_frame(32'd19, 40'd2048, 1'b0);     // just above the dead band
    add_frame(32'd32, 40'd2048, 1'b0);     // exposure at limit, gain moves
    add_frame('1, 40'd1, 1'b0);            // factor saturates
    add_frame(32'd18, 40'd2048, 1'b1);
    add_frame(32'd14, 40'd2048, 1'b0);
    add_frame(32'd13, 40'd2048, 1'b0);     // just below the dead band
    add_frame('0, '1, 1'b0);               // no pixels: full darkening
    add_frame('0, 40'd1, 1'b0);
    add_frame('0, 40'd2048, 1'b0);
    add_frame('0, 40'd2048, 1'b0);
    add_frame('0, 40'd2048, 1'b0);         // everything at its floor
    add_frame('1, '1, 1'b0);
    add_frame('1, '0, 1'b0);
    add_frame(32'd33, 40'd2048, 1'b0);
  endtask

  // runs of dark, bright or near-threshold frames, with some raw noise mixed in
  task automatic queue_random(input int unsigned n);
    int unsigned                run_left, f_lo, f_hi, fw;
    logic [aesc_pkg::PIX_W-1:0] pix;
    logic [aesc_pkg::SUM_W-1:0] sum;
    bit [63:0]                  num;
    run_left = 0;
    f_lo = 0;
    f_hi = 40;
    for (int unsigned i = 0; i < n; i++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(30, 3);
        case ($urandom_range(3, 0))
          0:       begin f_lo = 19; f_hi = 40; end
          1:       begin f_lo = 0;  f_hi = 13; end
          2:       begin f_lo = 12; f_hi = 20; end
          default: begin f_lo = 0;  f_hi = 40; end
        endcase
      end
      run_left--;
      if ($urandom_range(99, 0) < 85) begin
        pix = $urandom_range(32'h00ff_ffff, 1);
        if ($urandom_range(1, 0) == 1)
          pix = pix >> $urandom_range(20, 0);
        fw  = $urandom_range(f_hi, f_lo);
        num = 64'(pix) * 64'(tgt_luma) * 64'd16;
        if (num == 0) begin
          sum = {8'($urandom), 32'($urandom)};
        end else if (fw == 0) begin
          sum = {1'b1, 7'($urandom), 32'($urandom)};
        end else begin
          sum = aesc_pkg::SUM_W'(num / 64'(fw));
          if (sum == '0)
            sum = 40'd1;
        end
      end else begin
        pix = $urandom;
        sum = {8'($urandom), 32'($urandom)};
        case ($urandom_range(7, 0))
          0: sum = '0;
          1: pix = '0;
          2: begin pix = '1; sum = '1; end
          default: ;
        endcase
      end
      add_frame(pix, sum, $urandom_range(59, 0) == 0);
    end
  endtask

  initial begin : run
    int unsigned phase_items[6];
    phase_items = '{220, 120, 50, 180, 180, 150};
    stats_ch.valid       = 1'b0;
    stats_ch.pixel_count = '0;
    stats_ch.luma_total  = '0;
    upd_ch.ready         = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    program_loop(8'd128, 16'd4, 16'd20);
    queue_directed();
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: program_loop(8'd128, 16'hffff, 16'hffff);
        1: program_loop(8'd255, 16'd1, 16'd16);     // limits likely below the current values
        2: program_loop(8'd0, 16'd300, 16'd64);
        3: program_loop(8'($urandom_range(254, 1)), 16'($urandom_range(2000, 2)),
                        16'($urandom_range(400, 17)));
        4: program_loop(8'($urandom_range(255, 0)), 16'($urandom_range(65535, 1)),
                        16'($urandom_range(65535, 16)));
        default: program_loop(8'd128, 16'd40, 16'hffff);
      endcase
      queue_random(phase_items[ph]);
      wait_idle();
    end

    if (expected_updates.size() != 0) begin
      $error("tb: %0d updates never arrived", expected_updates.size());
      fail_count++;
    end
    $display("tb: %0d frames sent, %0d updates checked over %0d register settings",
             frames_sent, updates_checked, settings_used);
    $display("tb: exposure moved %0d times, sensor gain %0d, digital gain %0d",
             expo_moves, gain_moves, dgain_moves);
    if (fail_count == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
sv/aesc_pkg.sv
sv/aesc_if.sv
sv/aesc_queue.sv
sv/aesc_front.sv
sv/aesc_back.sv
sv/auto_exposure_step_controller_unit.sv
bench/tb.sv
